// ===== src/sfr_pkg.sv =====
// Package for the sync frame receiver: result status codes, the result word
// type, frame position constants and the rotate-xor checksum step.
// No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

    // Width of the frame byte counter; covers frames of up to 127 bytes.
    localparam int CNT_W = 7;
    typedef logic [CNT_W-1:0] t_count;

    // Status reported with each closed frame.
    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_BAD = 2'd1,
        STATUS_OVF = 2'd2
    } t_status;

    // One result word as it leaves the parser.
    typedef struct packed {
        t_status     status;
        logic [15:0] speed_one;
        logic [15:0] speed_two;
        logic [15:0] speed_three;
        logic        ended_by_new_start;
    } t_result;

    // Start word bytes in arrival order, and the start and tail patterns.
    localparam logic [7:0]  SYNC_B0    = 8'h55;
    localparam logic [7:0]  SYNC_B1    = 8'hFF;
    localparam logic [7:0]  SYNC_B2    = 8'h22;
    localparam logic [7:0]  SYNC_B3    = 8'h33;
    localparam logic [31:0] SYNC_WORD  = {SYNC_B0, SYNC_B1, SYNC_B2, SYNC_B3};
    localparam logic [15:0] TAIL_WORD  = 16'h99FF;

    // Frame positions (count of bytes already taken before this byte).
    localparam t_count POS_FIRST_DATA = t_count'(4);
    localparam t_count POS_LAST_CHECK = t_count'(19);
    localparam t_count POS_LAST_SPEED = t_count'(9);
    localparam t_count POS_CAP_HIGH   = t_count'(20);
    localparam t_count POS_CAP_LOW    = t_count'(21);

    // A tail closes a frame only beyond this count, a fresh start beyond the other.
    localparam t_count TAIL_MIN_COUNT  = t_count'(24 - 3);
    localparam t_count START_MIN_COUNT = t_count'(24 - 5);

    // One checksum step: xor the byte into the low half, then rotate left by one.
    function automatic logic [15:0] f_rotxor(input logic [15:0] sum, input logic [7:0] b);
        logic [15:0] x;
        x = sum ^ {8'h00, b};
        return {x[14:0], x[15]};
    endfunction

endpackage

// ===== src/sfr_parse.sv =====
// Frame parser: holds the frame state and, for each stepped byte, works out
// the next state and whether a result word is due. Uses sfr_pkg.
`timescale 1ns / 1ps

module sfr_parse
    import sfr_pkg::*;
#(
    parameter int MAX_FRAME = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_result_valid,
    output t_result    o_result
);

    localparam t_count LP_MAX = t_count'(MAX_FRAME);

    // Frame state.
    t_count      r_count,   n_count;
    logic [15:0] r_check,   n_check;
    logic [15:0] r_capture, n_capture;
    logic [31:0] r_recent,  n_recent;
    logic [7:0]  r_speed [0:5];

    t_count      w_inc;
    logic        w_mismatch;
    logic        w_end_tail;
    logic        w_end_start;
    logic        w_overflow;
    logic [15:0] w_check_upd;
    logic [2:0]  w_speed_idx;
    t_count      w_speed_off;

    // Per-byte checksum, capture and start word tracking.
    always_comb begin
        n_recent    = {r_recent[23:0], i_byte};
        w_check_upd = r_check;
        if (r_count >= POS_FIRST_DATA && r_count <= POS_LAST_CHECK) begin
            w_check_upd = f_rotxor(r_check, i_byte);
        end
        n_capture = r_capture;
        if (r_count == POS_CAP_HIGH) begin
            n_capture = {i_byte, r_capture[7:0]};
        end
        if (r_count == POS_CAP_LOW) begin
            n_capture = {r_capture[15:8], i_byte};
        end
        w_inc      = r_count + t_count'(1);
        w_mismatch = (r_count == t_count'(0) && i_byte != SYNC_B0) ||
                     (r_count == t_count'(1) && i_byte != SYNC_B1) ||
                     (r_count == t_count'(2) && i_byte != SYNC_B2) ||
                     (r_count == t_count'(3) && i_byte != SYNC_B3);
        if (w_mismatch) begin
            w_inc = '0;
        end
        w_end_tail  = (w_inc > TAIL_MIN_COUNT) && (n_recent[15:0] == TAIL_WORD);
        w_end_start = !w_end_tail && (w_inc > START_MIN_COUNT) && (n_recent == SYNC_WORD);
        w_overflow  = (w_inc >= LP_MAX);
        w_speed_off = r_count - POS_FIRST_DATA;
        w_speed_idx = w_speed_off[2:0];
    end

    // Next count and checksum, and the result word for a closing byte.
    always_comb begin
        n_count        = w_inc;
        n_check        = w_check_upd;
        o_result_valid = 1'b0;
        o_result       = '0;
        if (w_end_tail || w_end_start) begin
            // A fresh start word leaves the next frame with its start matched.
            n_count        = w_end_start ? POS_FIRST_DATA : '0;
            n_check        = '0;
            o_result_valid = 1'b1;
            o_result.ended_by_new_start = w_end_start;
            if (w_check_upd == n_capture) begin
                o_result.status      = STATUS_OK;
                o_result.speed_one   = {r_speed[0], r_speed[1]};
                o_result.speed_two   = {r_speed[2], r_speed[3]};
                o_result.speed_three = {r_speed[4], r_speed[5]};
            end else begin
                o_result.status = STATUS_BAD;
            end
        end else if (w_overflow) begin
            n_count         = '0;
            n_check         = '0;
            o_result_valid  = 1'b1;
            o_result.status = STATUS_OVF;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_check   <= '0;
            r_capture <= '0;
            r_recent  <= '0;
        end else if (i_step) begin
            r_count   <= n_count;
            r_check   <= n_check;
            r_capture <= n_capture;
            r_recent  <= n_recent;
        end
    end

    // Data bytes four to nine of the frame.
    always_ff @(posedge i_clk) begin
        if (i_step && r_count >= POS_FIRST_DATA && r_count <= POS_LAST_SPEED) begin
            r_speed[w_speed_idx] <= i_byte;
        end
    end

    // The counter never reaches the frame limit without a reset to zero.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < LP_MAX)
        else $error("frame byte count reached the frame limit");

endmodule

// ===== src/sync_frame_receiver_rotxor_check.sv =====
// Channel    Dir  Word                              Accepted when
// s_axis     in   tdata[7:0] = rx_byte              i_s_axis_tvalid & o_s_axis_tready
// m_axis     out  tdata = speeds, tuser = status    o_m_axis_tvalid & i_m_axis_tready
//
// One received byte is taken per cycle while the result side does not stall;
// each byte is registered in the input register, parsed from there, and its
// result is registered in the result register. The sustained rate is one byte
// per cycle when unstalled, set by the frame state update in sfr_parse. Reset
// (synchronous, active low) empties both registers and returns the parser to
// hunting. A stalled result holds the parser; input is still taken until the
// input register is full. Uses sfr_pkg and sfr_parse.
`timescale 1ns / 1ps

module sync_frame_receiver_rotxor_check
    import sfr_pkg::*;
#(
    parameter int MAX_FRAME = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [15:0] speed_one, [31:16] speed_two,
                                          // [47:32] speed_three
    output logic [2:0]  o_m_axis_tuser    // [1:0] frame_status, [2] ended_by_new_start
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_advance;
    logic       w_res_valid;
    t_result    w_res;

    // A byte moves through the parser whenever the result register can take it.
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    sfr_parse #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_advance),
        .i_byte         (r_in_byte),
        .o_result_valid (w_res_valid),
        .o_result       (w_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid <= w_advance && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.speed_three, r_out.speed_two, r_out.speed_one};
    assign o_m_axis_tuser  = {r_out.ended_by_new_start, r_out.status};

    // A byte held in the input register is not lost while the output stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_byte))
        else $error("input byte lost while stalled");

    // A dropped or mismatched frame carries no speeds.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status == STATUS_BAD || r_out.status == STATUS_OVF)
        |-> o_m_axis_tdata == '0)
        else $error("speeds present on a failed frame");

    // An overflow drop is never marked as closed by a start word.
    a_ovf_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == STATUS_OVF |-> !r_out.ended_by_new_start)
        else $error("overflow drop flagged as closed by start word");

    // A result is only loaded from a byte that went through the parser.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance && w_res_valid))
        else $error("result without a parsed byte");

endmodule

// ===== verif/tb_sync_frame_receiver_rotxor_check.sv =====
// Self-checking testbench for the sync frame receiver with rotate-xor check.
// Drives received bytes on the input stream and checks frame reports against
// a behavioural predictor. Depends on sfr_pkg and sync_frame_receiver_rotxor_check.
`timescale 1ns / 1ps

module tb_sync_frame_receiver_rotxor_check;
    import sfr_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int MAX_FRAME      = 64;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int LONG_HOLD      = 400;

    // How often a side pauses between words.
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_LIGHT = 1;
    localparam int IDLE_HEAVY = 2;

    // Content of the data, check padding and overflow bytes of a frame.
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    // How a generated frame is closed.
    localparam int END_TAIL        = 0;
    localparam int END_START       = 1;
    localparam int END_SHORT_START = 2;
    localparam int END_OVERFLOW    = 3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] rx_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;   // [15:0] speed_one, [31:16] speed_two, [47:32] speed_three
    logic [2:0]  o_m_axis_tuser;   // [1:0] frame_status, [2] ended_by_new_start

    // Predicted receiver state.
    t_count      frm_count = '0;
    logic [15:0] frm_sum = '0;
    logic [7:0]  frm_speed[6];
    logic [15:0] frm_check = '0;
    logic [31:0] last_four = '0;
    bit          restart_pending = 1'b0;

    t_result pending_reports[$];
    int      error_count = 0;
    int      bytes_sent = 0;
    int      src_idle_mode = IDLE_NONE;
    int      sink_idle_mode = IDLE_NONE;
    int      hold_off_cycles = 0;

    sync_frame_receiver_rotxor_check #(
        .MAX_FRAME(MAX_FRAME)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Advance the predicted receiver by one byte; returns 1 when a frame report is due.
    function automatic bit predict_frame_step(input logic [7:0] b, output t_result rpt);
        t_count      pos;
        t_count      nxt;
        logic [15:0] mixed;
        bit          at_tail;
        bit          at_start;
        bit          match;
        rpt = '0;
        if (restart_pending) begin
            frm_count = POS_FIRST_DATA;
            frm_sum = '0;
            restart_pending = 1'b0;
        end
        pos = frm_count;
        last_four = {last_four[23:0], b};

        if (pos >= POS_FIRST_DATA && pos <= POS_LAST_CHECK) begin
            mixed = frm_sum ^ {8'h00, b};
            frm_sum = {mixed[14:0], mixed[15]};
        end
        if (pos >= POS_FIRST_DATA && pos <= POS_LAST_SPEED)
            frm_speed[pos - POS_FIRST_DATA] = b;
        if (pos == POS_CAP_HIGH)
            frm_check[15:8] = b;
        if (pos == POS_CAP_LOW)
            frm_check[7:0] = b;

        // A byte that breaks the start word sends the hunt back to the beginning.
        nxt = pos + 1'b1;
        if ((nxt == 1 && b != SYNC_B0) || (nxt == 2 && b != SYNC_B1) ||
            (nxt == 3 && b != SYNC_B2) || (nxt == 4 && b != SYNC_B3))
            nxt = '0;
        frm_count = nxt;

        at_tail = nxt > TAIL_MIN_COUNT && last_four[15:0] == TAIL_WORD;
        at_start = !at_tail && nxt > START_MIN_COUNT && last_four == SYNC_WORD;
        if (at_tail || at_start) begin
            match = frm_sum == frm_check;
            rpt.status = match ? STATUS_OK : STATUS_BAD;
            if (match) begin
                rpt.speed_one = {frm_speed[0], frm_speed[1]};
                rpt.speed_two = {frm_speed[2], frm_speed[3]};
                rpt.speed_three = {frm_speed[4], frm_speed[5]};
            end
            rpt.ended_by_new_start = at_start;
            frm_count = '0;
            frm_sum = '0;
            restart_pending = at_start;
            return 1'b1;
        end

        // A frame that never ends is dropped at the size limit.
        if (nxt >= MAX_FRAME) begin
            rpt.status = STATUS_OVF;
            frm_count = '0;
            frm_sum = '0;
            restart_pending = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int draw_wait(input int mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 18) : 0;
            default:    return $urandom_range(0, 18);
        endcase
    endfunction

    function automatic logic [7:0] start_byte(input int k);
        return SYNC_WORD[31 - 8 * k -: 8];
    endfunction

    // Random content leans towards the bytes that the framing logic looks for.
    function automatic logic [7:0] fill_byte(input int fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default: begin
                if ($urandom_range(0, 7) != 0)
                    return 8'($urandom_range(0, 255));
                case ($urandom_range(0, 3))
                    0:       return TAIL_WORD[15:8];
                    1:       return SYNC_B0;
                    2:       return SYNC_B2;
                    default: return SYNC_B3;
                endcase
            end
        endcase
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        end
    endfunction

    // Offer one byte after a random pause and wait until the block takes the word.
    task automatic send_rx_byte(input logic [7:0] b);
        int      gap;
        t_result rpt;
        gap = draw_wait(src_idle_mode);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
        if (predict_frame_step(b, rpt))
            pending_reports.push_back(rpt);
    endtask

    // Build one frame, with a matching or broken check word unless it is short, and send it.
    task automatic send_frame(input bit with_start, input int fill, input int ending,
                              input bit good_check, output bit chained);
        logic [7:0]  frame_bytes[$];
        logic [15:0] sum;
        logic [15:0] mixed;
        logic [7:0]  v;
        int          n_data;
        int          base;
        sum = '0;
        base = with_start ? 0 : 4;
        if (with_start)
            for (int k = 0; k < 4; k++) frame_bytes.push_back(start_byte(k));

        // A short frame stops its data early so that the next start word closes it.
        n_data = (ending == END_SHORT_START) ? $urandom_range(12, 14) : 16;
        for (int k = 0; k < n_data; k++) begin
            v = fill_byte(fill);
            mixed = sum ^ {8'h00, v};
            sum = {mixed[14:0], mixed[15]};
            frame_bytes.push_back(v);
        end
        if (ending != END_SHORT_START) begin
            if (!good_check)
                sum = sum ^ (16'h0001 << $urandom_range(0, 15));
            frame_bytes.push_back(sum[15:8]);
            frame_bytes.push_back(sum[7:0]);
            repeat ($urandom_range(0, 6)) frame_bytes.push_back(fill_byte(fill));
        end

        case (ending)
            END_TAIL: begin
                frame_bytes.push_back(TAIL_WORD[15:8]);
                frame_bytes.push_back(TAIL_WORD[7:0]);
            end
            END_OVERFLOW: begin
                while (base + frame_bytes.size() < MAX_FRAME)
                    frame_bytes.push_back(fill_byte(fill));
            end
            default: begin
                for (int k = 0; k < 4; k++) frame_bytes.push_back(start_byte(k));
            end
        endcase
        chained = (ending == END_START || ending == END_SHORT_START);
        foreach (frame_bytes[k]) send_rx_byte(frame_bytes[k]);
    endtask

    // Line noise, a repeated first start byte and a start word broken at its last byte.
    task automatic test_hunting();
        src_idle_mode = IDLE_LIGHT;
        sink_idle_mode = IDLE_LIGHT;
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        send_rx_byte(SYNC_B0);
        for (int k = 0; k < 4; k++) send_rx_byte(start_byte(k));
        for (int k = 0; k < 3; k++) send_rx_byte(start_byte(k));
        send_rx_byte(8'h00);
    endtask

    // Good frames with all-zero, all-one and random content.
    task automatic test_good_frames();
        bit chained;
        send_frame(1'b1, FILL_ZERO, END_TAIL, 1'b1, chained);
        send_frame(1'b1, FILL_ONES, END_TAIL, 1'b1, chained);
        send_frame(1'b1, FILL_RANDOM, END_TAIL, 1'b1, chained);
    endtask

    task automatic test_bad_check();
        bit chained;
        send_frame(1'b1, FILL_RANDOM, END_TAIL, 1'b0, chained);
        send_frame(1'b1, FILL_ONES, END_TAIL, 1'b0, chained);
    endtask

    // A fresh start word closes a frame; the next one starts with its start matched.
    task automatic test_new_start_close();
        bit chained;
        send_frame(1'b1, FILL_RANDOM, END_START, 1'b1, chained);
        send_frame(1'b0, FILL_RANDOM, END_START, 1'b0, chained);
        send_frame(1'b0, FILL_RANDOM, END_TAIL, 1'b1, chained);
    endtask

    // Short frames compare against the check word left over from an earlier frame.
    task automatic test_short_frame();
        bit chained;
        send_frame(1'b1, FILL_RANDOM, END_SHORT_START, 1'b1, chained);
        send_frame(1'b0, FILL_ZERO, END_SHORT_START, 1'b1, chained);
        send_frame(1'b0, FILL_RANDOM, END_TAIL, 1'b1, chained);
    endtask

    task automatic test_overflow();
        bit chained;
        send_frame(1'b1, FILL_ONES, END_OVERFLOW, 1'b1, chained);
        send_frame(1'b1, FILL_RANDOM, END_START, 1'b1, chained);
        send_frame(1'b0, FILL_ZERO, END_OVERFLOW, 1'b1, chained);
    endtask

    // The sink stops for a long stretch while bytes keep coming at full rate.
    task automatic test_backpressure();
        bit chained;
        src_idle_mode = IDLE_NONE;
        sink_idle_mode = IDLE_NONE;
        hold_off_cycles = LONG_HOLD;
        repeat (6) send_frame(1'b1, FILL_RANDOM, END_TAIL, 1'b1, chained);
    endtask

    // Mostly well-formed frames with random content, mixed with noise and broken starts.
    task automatic test_random_traffic();
        bit chained;
        int stop_at;
        int pick;
        int fill;
        int ending;
        int k;
        chained = 1'b0;
        stop_at = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0) begin
                src_idle_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
                sink_idle_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
            end
            if (chained || $urandom_range(0, 9) < 8) begin
                pick = $urandom_range(0, 19);
                if (pick < 10)
                    ending = END_TAIL;
                else if (pick < 15)
                    ending = END_START;
                else if (pick < 19)
                    ending = END_SHORT_START;
                else
                    ending = END_OVERFLOW;
                pick = $urandom_range(0, 15);
                fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;
                send_frame(!chained, fill, ending, $urandom_range(0, 4) != 0, chained);
            end else if ($urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(1, 8)) send_rx_byte(fill_byte(FILL_RANDOM));
            end else begin
                k = $urandom_range(1, 3);
                for (int j = 0; j < k; j++) send_rx_byte(start_byte(j));
                send_rx_byte(start_byte(k) ^ 8'($urandom_range(1, 255)));
            end
        end
    endtask

    // Sink side: accept each report after a random stall and compare it field by field.
    initial begin : report_sink
        int      wait_cycles;
        t_result want;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wait_cycles = draw_wait(sink_idle_mode);
            if (hold_off_cycles > 0) begin
                wait_cycles = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (wait_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);

            if (pending_reports.size() == 0) begin
                error_count++;
                $display("%0t: unexpected report: expected none, actual status %0d data %h",
                         $time, o_m_axis_tuser[1:0], o_m_axis_tdata);
            end else begin
                want = pending_reports.pop_front();
                check_field("frame_status", 16'(want.status), 16'(o_m_axis_tuser[1:0]));
                check_field("speed_one", want.speed_one, o_m_axis_tdata[15:0]);
                check_field("speed_two", want.speed_two, o_m_axis_tdata[31:16]);
                check_field("speed_three", want.speed_three, o_m_axis_tdata[47:32]);
                check_field("ended_by_new_start", 16'(want.ended_by_new_start),
                            16'(o_m_axis_tuser[2]));
            end
        end
    end

    // Main sequence: reset once, run every test, then drain the outstanding reports.
    initial begin : stimulus
        int waited;
        i_rst_n <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_hunting();
        test_good_frames();
        test_bad_check();
        test_new_start_close();
        test_short_frame();
        test_overflow();
        test_backpressure();
        test_random_traffic();

        i_s_axis_tvalid <= 1'b0;
        sink_idle_mode = IDLE_NONE;
        waited = 0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_reports.size() != 0) begin
            error_count++;
            $display("%0t: reports still outstanding: expected 0, actual %0d",
                     $time, pending_reports.size());
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sfr_pkg.sv
src/sfr_parse.sv
src/sync_frame_receiver_rotxor_check.sv
verif/tb_sync_frame_receiver_rotxor_check.sv
